// ----- hw/rtl/timed_task_queue_scheduler_macros.svh -----
// Assertion macros shared by the timed task queue scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TIMED_TASK_QUEUE_SCHEDULER_MACROS_SVH
`define TIMED_TASK_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTQS_CHECK(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTQS_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ----- hw/rtl/ttqs_pkg.sv -----
// Shared types and codes for the timed task queue scheduler.
// No dependencies; used by every RTL module of the block.
package ttqs_pkg;

    localparam logic [3:0] ACT_STEP        = 4'd0;
    localparam logic [3:0] ACT_AT          = 4'd1;
    localparam logic [3:0] ACT_IN          = 4'd2;
    localparam logic [3:0] ACT_NOW         = 4'd3;
    localparam logic [3:0] ACT_RESCHED_IN  = 4'd4;
    localparam logic [3:0] ACT_RESCHED_NOW = 4'd5;
    localparam logic [3:0] ACT_REMOVE      = 4'd6;
    localparam logic [3:0] ACT_STATUS      = 4'd7;
    localparam logic [3:0] ACT_DONE        = 4'd8;
    localparam logic [3:0] ACT_RESET       = 4'd9;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_RUNNABLE = 2'd2;
    localparam logic [1:0] ST_FUTURE   = 2'd3;

    typedef struct packed {
        logic [3:0]         action;
        logic [3:0]         task_req;
        logic [31:0]        time_value;
        logic signed [31:0] delta;
        logic [31:0]        now;
    } t_in_word;

    typedef struct packed {
        logic [3:0] dispatched_task;
        logic       ran_idle;
        logic       removed;
        logic [1:0] task_status;
        logic [4:0] queued_count;
        logic       queue_empty;
        logic [3:0] next_task;
        logic       next_valid;
        logic       error;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_CALC,
        OP_UNLINK,
        OP_INSERT,
        OP_RESULT
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic ins_pend;
    } t_sts;

endpackage

// ----- hw/rtl/ttqs_ctrl.sv -----
// Sequencing state machine of the timed task queue scheduler.
// Depends on ttqs_pkg for the command and status structs.
module ttqs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ttqs_pkg::t_sts  i_sts,
    output ttqs_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_UNLINK,
        S_INSERT,
        S_FINISH
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_READ;
                S_READ:   r_state <= S_CALC;
                S_CALC:   r_state <= S_UNLINK;
                S_UNLINK: r_state <= i_sts.ins_pend ? S_INSERT : S_FINISH;
                S_INSERT: r_state <= S_FINISH;
                S_FINISH: if (!i_sts.out_busy) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_READ:   o_cmd.op = ttqs_pkg::OP_READ;
            S_CALC:   o_cmd.op = ttqs_pkg::OP_CALC;
            S_UNLINK: o_cmd.op = ttqs_pkg::OP_UNLINK;
            S_INSERT: o_cmd.op = ttqs_pkg::OP_INSERT;
            S_FINISH: o_cmd.op = i_sts.out_busy ? ttqs_pkg::OP_NONE : ttqs_pkg::OP_RESULT;
            default:  o_cmd.op = ttqs_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/ttqs_dp.sv -----
// Datapath of the timed task queue scheduler: sorted cell chain, due time
// memory, current task and result register. Depends on ttqs_pkg and the macros.
`include "timed_task_queue_scheduler_macros.svh"

module ttqs_dp #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ttqs_pkg::t_cmd      i_cmd,
    output ttqs_pkg::t_sts      o_sts,
    input  ttqs_pkg::t_in_word  i_in_word,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ttqs_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = TIME_BITS;

    function automatic logic [AW-1:0] to_addr(input logic [3:0] id);
        return AW'(id);
    endfunction

    // Not after: wrapping difference a - b is zero or negative.
    function automatic logic t_le(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW-1:0] d;
        d = a - b;
        return (d == '0) || d[TW-1];
    endfunction

    ttqs_pkg::t_in_word  r_in;
    ttqs_pkg::t_out_word r_out;
    logic                r_out_v;
    logic [TW-1:0]       r_due [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_tv;
    logic [MAX_TASKS-1:0] r_qf;
    logic [TW-1:0]       r_rd;
    logic                r_rd_v;
    logic [3:0]          r_cell_id   [MAX_TASKS];
    logic [TW-1:0]       r_cell_time [MAX_TASKS];
    logic [CW-1:0]       r_count;
    logic [3:0]          r_cur_id;
    logic                r_cur_v;
    logic [3:0]          r_idle;
    logic [TW-1:0]       r_new_time;
    logic [3:0]          r_ins_id;
    logic                r_unl;
    logic                r_ins_pend;
    logic [3:0]          r_disp;
    logic                r_ran_idle;
    logic                r_removed;
    logic [1:0]          r_status;
    logic                r_err;

    logic [TW-1:0] w_now, w_tval, w_dlt, w_due, w_new_time;
    logic          w_tid_ok, w_resched, w_sched, w_head_due;
    logic [AW-1:0] w_rd_addr, w_ins_addr;
    logic [1:0]    w_status;
    logic [MAX_TASKS-1:0] w_shift, w_keep, w_prev_keep;
    logic [3:0]    w_up_id   [MAX_TASKS];
    logic [TW-1:0] w_up_time [MAX_TASKS];
    logic [3:0]    w_dn_id   [MAX_TASKS];
    logic [TW-1:0] w_dn_time [MAX_TASKS];

    assign w_now      = TW'(r_in.now);
    assign w_tval     = TW'(r_in.time_value);
    assign w_dlt      = TW'(r_in.delta);
    assign w_tid_ok   = {28'd0, r_in.task_req} < 32'(MAX_TASKS);
    assign w_resched  = (r_in.action == ttqs_pkg::ACT_RESCHED_IN) ||
                        (r_in.action == ttqs_pkg::ACT_RESCHED_NOW);
    assign w_rd_addr  = w_resched ? to_addr(r_cur_id) : to_addr(r_in.task_req);
    assign w_ins_addr = to_addr(r_ins_id);
    assign w_due      = r_rd_v ? r_rd : '0;
    assign w_head_due = (r_count != '0) && t_le(r_cell_time[0], w_now);

    always_comb begin
        unique case (r_in.action)
            ttqs_pkg::ACT_AT:         w_new_time = w_tval;
            ttqs_pkg::ACT_IN:         w_new_time = w_now + w_dlt;
            ttqs_pkg::ACT_RESCHED_IN: w_new_time = w_due + w_dlt;
            default:                  w_new_time = w_now;
        endcase
    end

    always_comb begin
        w_sched = 1'b0;
        if (r_in.action == ttqs_pkg::ACT_AT || r_in.action == ttqs_pkg::ACT_IN ||
            r_in.action == ttqs_pkg::ACT_NOW) begin
            w_sched = w_tid_ok;
        end else if (w_resched) begin
            w_sched = r_cur_v;
        end
    end

    always_comb begin
        priority if (r_cur_v && r_cur_id == r_in.task_req) begin
            w_status = ttqs_pkg::ST_ACTIVE;
        end else if (!w_tid_ok) begin
            w_status = ttqs_pkg::ST_IDLE;
        end else if (!r_qf[to_addr(r_in.task_req)]) begin
            w_status = ttqs_pkg::ST_IDLE;
        end else if (t_le(w_due, w_now)) begin
            w_status = ttqs_pkg::ST_RUNNABLE;
        end else begin
            w_status = ttqs_pkg::ST_FUTURE;
        end
    end

    // Neighbor taps of the cell chain.
    always_comb begin
        for (int i = 0; i < MAX_TASKS - 1; i++) begin
            w_up_id[i]   = r_cell_id[i+1];
            w_up_time[i] = r_cell_time[i+1];
        end
        w_up_id[MAX_TASKS-1]   = r_cell_id[MAX_TASKS-1];
        w_up_time[MAX_TASKS-1] = r_cell_time[MAX_TASKS-1];
        w_dn_id[0]   = r_ins_id;
        w_dn_time[0] = r_new_time;
        for (int i = 1; i < MAX_TASKS; i++) begin
            w_dn_id[i]   = r_cell_id[i-1];
            w_dn_time[i] = r_cell_time[i-1];
        end
    end

    // Broadcast compares: the matching cell and all after it shift down on
    // unlink; cells up to the last one not after the new time stay on insert.
    always_comb begin
        logic          hit;
        logic          keep;
        logic [TW-1:0] d;
        hit  = 1'b0;
        keep = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (CW'(i) < r_count && r_cell_id[i] == r_ins_id) hit = 1'b1;
            w_shift[i]     = hit;
            w_prev_keep[i] = keep;
            d    = r_new_time - r_cell_time[i];
            keep = keep && (CW'(i) < r_count) && !d[TW-1];
            w_keep[i] = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_word;
        if (i_cmd.op == ttqs_pkg::OP_READ) r_rd <= r_due[w_rd_addr];
        if (i_cmd.op == ttqs_pkg::OP_CALC) begin
            r_new_time <= w_new_time;
            if (w_sched) r_due[w_rd_addr] <= w_new_time;
        end
        if (i_cmd.op == ttqs_pkg::OP_UNLINK && r_unl && r_qf[w_ins_addr]) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (w_shift[i]) begin
                    r_cell_id[i]   <= w_up_id[i];
                    r_cell_time[i] <= w_up_time[i];
                end
            end
        end
        if (i_cmd.op == ttqs_pkg::OP_INSERT && r_ins_pend && r_count < CW'(MAX_TASKS)) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (!w_keep[i]) begin
                    r_cell_id[i]   <= w_prev_keep[i] ? r_ins_id   : w_dn_id[i];
                    r_cell_time[i] <= w_prev_keep[i] ? r_new_time : w_dn_time[i];
                end
            end
        end
        if (i_cmd.op == ttqs_pkg::OP_RESULT) begin
            r_out.dispatched_task <= r_disp;
            r_out.ran_idle        <= r_ran_idle;
            r_out.removed         <= r_removed;
            r_out.task_status     <= r_status;
            r_out.queued_count    <= 5'(r_count);
            r_out.queue_empty     <= (r_count == '0);
            r_out.next_task       <= (r_count != '0) ? r_cell_id[0] : 4'd0;
            r_out.next_valid      <= (r_count != '0);
            r_out.error           <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv       <= '0;
            r_qf       <= '0;
            r_rd_v     <= 1'b0;
            r_count    <= '0;
            r_cur_id   <= 4'd0;
            r_cur_v    <= 1'b0;
            r_idle     <= 4'd0;
            r_out_v    <= 1'b0;
            r_ins_id   <= 4'd0;
            r_unl      <= 1'b0;
            r_ins_pend <= 1'b0;
            r_disp     <= 4'd0;
            r_ran_idle <= 1'b0;
            r_removed  <= 1'b0;
            r_status   <= ttqs_pkg::ST_IDLE;
            r_err      <= 1'b0;
        end else begin
            if (i_cfg_we) r_idle <= i_cfg_data;
            if (i_cmd.load) begin
                r_disp     <= r_idle;
                r_ran_idle <= 1'b0;
                r_removed  <= 1'b0;
                r_status   <= ttqs_pkg::ST_IDLE;
                r_err      <= 1'b0;
                r_unl      <= 1'b0;
                r_ins_pend <= 1'b0;
            end
            if (i_cmd.op == ttqs_pkg::OP_READ) r_rd_v <= r_tv[w_rd_addr];
            if (i_cmd.op == ttqs_pkg::OP_CALC) begin
                if (w_sched) r_tv[w_rd_addr] <= 1'b1;
                unique case (r_in.action)
                    ttqs_pkg::ACT_STEP: begin
                        if (w_head_due) begin
                            r_cur_id <= r_cell_id[0];
                            r_cur_v  <= 1'b1;
                            r_disp   <= r_cell_id[0];
                            r_ins_id <= r_cell_id[0];
                            r_unl    <= 1'b1;
                        end else begin
                            r_cur_v    <= 1'b0;
                            r_ran_idle <= 1'b1;
                        end
                    end
                    ttqs_pkg::ACT_AT, ttqs_pkg::ACT_IN, ttqs_pkg::ACT_NOW: begin
                        if (w_tid_ok) begin
                            r_ins_id   <= r_in.task_req;
                            r_unl      <= 1'b1;
                            r_ins_pend <= 1'b1;
                        end
                    end
                    ttqs_pkg::ACT_RESCHED_IN, ttqs_pkg::ACT_RESCHED_NOW: begin
                        if (!r_cur_v) begin
                            r_err <= 1'b1;
                        end else begin
                            r_ins_id   <= r_cur_id;
                            r_unl      <= 1'b1;
                            r_ins_pend <= 1'b1;
                        end
                    end
                    ttqs_pkg::ACT_REMOVE: begin
                        if (w_tid_ok && r_qf[to_addr(r_in.task_req)]) begin
                            r_removed <= 1'b1;
                            r_ins_id  <= r_in.task_req;
                            r_unl     <= 1'b1;
                        end
                    end
                    ttqs_pkg::ACT_STATUS: r_status <= w_status;
                    ttqs_pkg::ACT_DONE:   r_cur_v <= 1'b0;
                    ttqs_pkg::ACT_RESET: begin
                        r_qf    <= '0;
                        r_count <= '0;
                        r_cur_v <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.op == ttqs_pkg::OP_UNLINK && r_unl && r_qf[w_ins_addr]) begin
                r_count          <= r_count - 1'b1;
                r_qf[w_ins_addr] <= 1'b0;
            end
            if (i_cmd.op == ttqs_pkg::OP_INSERT && r_ins_pend && r_count < CW'(MAX_TASKS)) begin
                r_count          <= r_count + 1'b1;
                r_qf[w_ins_addr] <= 1'b1;
            end
            if (i_cmd.op == ttqs_pkg::OP_RESULT) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_v && i_out_stall;
    assign o_sts.ins_pend = r_ins_pend;
    assign o_out_valid    = r_out_v;
    assign o_out_word     = r_out;

    `TTQS_CHECK(a_count_matches_flags, i_clk, i_rst_n, 1'b1, $countones(r_qf) == int'(r_count))
    `TTQS_NEXT(a_insert_sets_flag, i_clk, i_rst_n, i_cmd.op == ttqs_pkg::OP_INSERT && r_ins_pend && r_count < CW'(MAX_TASKS), r_qf[$past(w_ins_addr)])
    `TTQS_NEXT(a_unlink_clears_flag, i_clk, i_rst_n, i_cmd.op == ttqs_pkg::OP_UNLINK && r_unl, !r_qf[$past(w_ins_addr)])

endmodule

// ----- hw/rtl/timed_task_queue_scheduler.sv -----
// Top level of the timed task queue scheduler.
// Depends on ttqs_pkg, ttqs_ctrl and ttqs_dp.
//
// Channel  | Direction | Handshake                | Word
// ---------+-----------+--------------------------+----------------------------
// input    | in        | i_in_valid / o_in_stall  | i_in_word (t_in_word)
// result   | out       | o_out_valid / i_out_stall| o_out_word (t_out_word)
// config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_data (idle task id)
//
// One word is processed at a time. The result register loads after the read,
// compute, unlink and finish steps, with an insert step before finish when a task
// is inserted; the single-port due-time memory read and the one-cell-chain pass
// per unlink or insert set these steps. The next word can be accepted the cycle
// after the result loads. A new word is accepted even while the previous result
// is stalled; its own finish step then waits until that result has left.
// Reset is synchronous and active low; it empties the queue and clears the
// current task. The config port is always ready.
module timed_task_queue_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ttqs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ttqs_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data
);

    ttqs_pkg::t_cmd w_cmd;
    ttqs_pkg::t_sts w_sts;

    // The idle id register is written whenever the config word arrives.
    assign o_cfg_ready = 1'b1;

    // The controller steps the datapath through each word's phases.
    ttqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the sorted cell chain, due times and the result word.
    ttqs_dp #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
